>>> sv/sfma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scalar field modular arithmetic block.
// No dependencies; imported by every module of the block.
package sfma_pkg;

    localparam int WORD_W  = 256;
    localparam int FIELD_W = 255;
    localparam int LIMB_W  = 64;
    localparam int CNT_W   = 8;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [LIMB_W-1:0]  limb_t;
    typedef logic [2:0]         cmd_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Field modulus q (255-bit prime).
    localparam field_t Q_MOD =
        255'h40000000000000000000000000000000224698fc0994a8dd8c46eb2100000001;

    localparam cmd_t CMD_ABSORB = 3'd0;
    localparam cmd_t CMD_FINISH = 3'd1;
    localparam cmd_t CMD_ADD    = 3'd2;
    localparam cmd_t CMD_MUL    = 3'd3;
    localparam cmd_t CMD_REDUCE = 3'd4;

    // Start value of each bit loop's counter (counts down to zero).
    localparam cnt_t MUL_LAST    = cnt_t'(WORD_W - 1);
    localparam cnt_t ABSORB_LAST = cnt_t'(7);
    localparam cnt_t RED_LAST    = cnt_t'(1);

endpackage

>>> sv/scalar_field_mod_arith.sv
`timescale 1ns / 1ps
// Top level: command sequencer around one shared modular adder.
// Depends on sfma_pkg and sfma_modadd.
//
// Usage:
//   One transaction on the s_ channel carries a command and its operands;
//   exactly one result transaction follows on the m_ channel, always below q.
//   s_ready is high only while the sequencer is idle; a new command may be
//   taken while the previous result still sits in the output register.
//   Steps from acceptance to m_valid (one pass of the modular adder a cycle):
//     finish, undefined command : output state only
//     absorb_byte               : one byte bit per pass, then output
//     reduce                    : two passes on operand a, then output
//     add                       : reduce a, reduce b, one add pass, then output
//     mul                       : reduce a and b, double-and-add one bit a pass, output
//   The modular adder is the only arithmetic, so no new command is taken until
//   the previous one has left the output state and the sequencer is idle.
//   A stalled receiver holds the result in the output register; a finished
//   command waits in its output state until that register frees up.
//   Synchronous active-low reset clears the sequencer, m_valid and acc.
module scalar_field_mod_arith (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfma_pkg::cmd_t      s_cmd,
    input  logic [7:0]          s_data_byte,
    input  sfma_pkg::limb_t     s_opa_w0,
    input  sfma_pkg::limb_t     s_opa_w1,
    input  sfma_pkg::limb_t     s_opa_w2,
    input  sfma_pkg::limb_t     s_opa_w3,
    input  sfma_pkg::limb_t     s_opb_w0,
    input  sfma_pkg::limb_t     s_opb_w1,
    input  sfma_pkg::limb_t     s_opb_w2,
    input  sfma_pkg::limb_t     s_opb_w3,
    output logic                m_valid,
    input  logic                m_ready,
    output sfma_pkg::limb_t     m_res_w0,
    output sfma_pkg::limb_t     m_res_w1,
    output sfma_pkg::limb_t     m_res_w2,
    output logic [62:0]         m_res_w3
);
    import sfma_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED_A = 3'd1;
    localparam logic [2:0] S_RED_B = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    cmd_t       cmd_reg, cmd_next;
    word_t      a_reg, a_next;
    word_t      b_reg, b_next;
    word_t      t_reg, t_next;
    field_t     acc_reg, acc_next;
    logic       m_valid_reg, m_valid_next;
    field_t     res_reg, res_next;

    word_t      unit_x;
    word_t      unit_y;
    word_t      unit_r;

    sfma_modadd u_modadd (
        .x (unit_x),
        .y (unit_y),
        .r (unit_r)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        unit_x       = '0;
        unit_y       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_cmd;
                    a_next   = {s_opa_w3, s_opa_w2, s_opa_w1, s_opa_w0};
                    b_next   = {s_opb_w3, s_opb_w2, s_opb_w1, s_opb_w0};
                    cnt_next = RED_LAST;
                    unique case (s_cmd) inside
                        CMD_ABSORB: begin
                            // Horner over the byte bits: t = 2t + bit.
                            a_next     = {s_data_byte, {(WORD_W-8){1'b0}}};
                            b_next     = word_t'(1);
                            t_next     = {1'b0, acc_reg};
                            cnt_next   = ABSORB_LAST;
                            state_next = S_MUL;
                        end
                        CMD_FINISH: begin
                            t_next     = (acc_reg == '0) ? word_t'(1) : {1'b0, acc_reg};
                            acc_next   = '0;
                            state_next = S_OUT;
                        end
                        CMD_ADD, CMD_MUL, CMD_REDUCE: begin
                            state_next = S_RED_A;
                        end
                        default: begin
                            t_next     = '0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RED_A: begin
                unit_x   = a_reg;
                a_next   = unit_r;
                cnt_next = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0) begin
                    cnt_next = RED_LAST;
                    if (cmd_reg == CMD_REDUCE) begin
                        t_next     = unit_r;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_RED_B;
                    end
                end
            end
            S_RED_B: begin
                unit_x   = b_reg;
                b_next   = unit_r;
                cnt_next = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0) begin
                    if (cmd_reg == CMD_ADD) begin
                        state_next = S_ADD;
                    end else begin
                        t_next     = '0;
                        cnt_next   = MUL_LAST;
                        state_next = S_MUL;
                    end
                end
            end
            S_ADD: begin
                unit_x     = a_reg;
                unit_y     = b_reg;
                t_next     = unit_r;
                state_next = S_OUT;
            end
            S_MUL: begin
                // Double and conditionally add in one pass, multiplier MSB first.
                unit_x   = {t_reg[WORD_W-2:0], 1'b0};
                unit_y   = a_reg[WORD_W-1] ? b_reg : '0;
                t_next   = unit_r;
                a_next   = {a_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg - cnt_t'(1);
                if (cnt_reg == '0) begin
                    state_next = S_OUT;
                    if (cmd_reg == CMD_ABSORB) begin
                        acc_next = unit_r[FIELD_W-1:0];
                    end
                end
            end
            S_OUT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    res_next     = t_reg[FIELD_W-1:0];
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        cmd_reg <= cmd_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        t_reg   <= t_next;
        res_reg <= res_next;
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_res_w0 = res_reg[63:0];
    assign m_res_w1 = res_reg[127:64];
    assign m_res_w2 = res_reg[191:128];
    assign m_res_w3 = res_reg[254:192];

    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg < Q_MOD)
        else $error("accumulator not reduced below q");

    a_mul_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (t_reg < {1'b0, Q_MOD}))
        else $error("partial product not reduced below q");

    a_res_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg < Q_MOD))
        else $error("result not reduced below q");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == CMD_FINISH)) |=> (acc_reg == '0))
        else $error("finish did not clear the accumulator");

endmodule

>>> sv/sfma_modadd.sv
`timescale 1ns / 1ps
// Shared modular adder: returns x + y with up to two subtractions of q.
// Depends on sfma_pkg. Result is below q whenever x + y < 3q.
module sfma_modadd (
    input  sfma_pkg::word_t x,
    input  sfma_pkg::word_t y,
    output sfma_pkg::word_t r
);
    import sfma_pkg::*;

    localparam logic [WORD_W+1:0] Q1 = {3'b000, Q_MOD};
    localparam logic [WORD_W+1:0] Q2 = {2'b00, Q_MOD, 1'b0};

    logic [WORD_W+1:0] sum;
    logic [WORD_W+1:0] dif1;
    logic [WORD_W+1:0] dif2;

    // All three candidates in parallel; the sign bit picks the smallest
    // non-negative one.
    assign sum  = {2'b00, x} + {2'b00, y};
    assign dif1 = {2'b00, x} + {2'b00, y} - Q1;
    assign dif2 = {2'b00, x} + {2'b00, y} - Q2;

    always_comb begin
        if (!dif2[WORD_W+1]) begin
            r = dif2[WORD_W-1:0];
        end else if (!dif1[WORD_W+1]) begin
            r = dif1[WORD_W-1:0];
        end else begin
            r = sum[WORD_W-1:0];
        end
    end

endmodule

>>> dv/scalar_field_mod_arith_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scalar_field_mod_arith: queued commands go in over s_,
// results on m_ are checked in order against a wide-integer model of the field unit.
// Depends on sfma_pkg and the block's RTL.
module testbench;
    import sfma_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned TOTAL_ITEMS  = RANDOM_ITEMS + 25;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned MAX_PRINTS   = 40;

    localparam cmd_t         CMD_UNDEF_FIRST = CMD_REDUCE + cmd_t'(1);
    localparam cmd_t         CMD_UNDEF_LAST  = '1;
    localparam logic [511:0] Q_WIDE          = {257'b0, Q_MOD};
    localparam word_t        Q_WORD          = {1'b0, Q_MOD};
    localparam word_t        ALL_ONES        = '1;

    typedef struct {
        cmd_t        cmd;
        logic [7:0]  data_byte;
        word_t       opa;
        word_t       opb;
        int unsigned phase;
    } field_cmd_t;

    typedef struct {
        cmd_t        cmd;
        field_t      value;
        int unsigned seq;
    } field_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    cmd_t        s_cmd       = CMD_ABSORB;
    logic [7:0]  s_data_byte = '0;
    limb_t       s_opa_w0    = '0;
    limb_t       s_opa_w1    = '0;
    limb_t       s_opa_w2    = '0;
    limb_t       s_opa_w3    = '0;
    limb_t       s_opb_w0    = '0;
    limb_t       s_opb_w1    = '0;
    limb_t       s_opb_w2    = '0;
    limb_t       s_opb_w3    = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    limb_t       m_res_w0;
    limb_t       m_res_w1;
    limb_t       m_res_w2;
    logic [62:0] m_res_w3;

    field_cmd_t    cmd_q[$];
    field_cmd_t    cur_cmd;
    field_result_t result_q[$];
    field_t        acc_shadow  = '0;
    logic          s_taken     = 1'b0;
    int unsigned   cur_phase   = 0;
    int unsigned   n_queued    = 0;
    int unsigned   n_accepted  = 0;
    int unsigned   n_errors    = 0;

    // Per phase: free running, sender gaps, receiver stalls, both.
    int unsigned tx_idle_pct[4]  = '{0, 46, 0, 13};
    int unsigned rx_stall_pct[4] = '{0, 0, 46, 13};

    scalar_field_mod_arith i_dut (.*);

    always #1 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (n_errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic push_cmd(input cmd_t cmd, input logic [7:0] data_byte,
                            input word_t opa, input word_t opb);
        field_cmd_t c;
        c.cmd       = cmd;
        c.data_byte = data_byte;
        c.opa       = opa;
        c.opb       = opb;
        c.phase     = (n_queued * 4) / TOTAL_ITEMS;
        if (c.phase > 3) c.phase = 3;
        cmd_q.push_back(c);
        n_queued++;
    endtask

    // Mix of plain random words, zero, all ones, small values and values at or near multiples of q.
    function automatic word_t rand_operand();
        word_t w;
        word_t mult;
        for (int i = 0; i < 8; i++) w[32*i +: 32] = $urandom;
        case ($urandom_range(9)) inside
            0: w = '0;
            1: w = ALL_ONES;
            2: w = word_t'($urandom);
            3, 4: begin
                mult = word_t'($urandom_range(1, 3));
                if ($urandom_range(1) == 0) w = Q_WORD * mult + word_t'($urandom_range(3));
                else w = Q_WORD * mult - word_t'($urandom_range(1, 4));
            end
            default: ;
        endcase
        return w;
    endfunction

    // Advance the shadow accumulator and return the reduced field value for one command.
    function automatic field_t field_step(input field_cmd_t c);
        logic [511:0] lhs;
        logic [511:0] rhs;
        field_t       r;
        r   = '0;
        lhs = {256'b0, c.opa} % Q_WIDE;
        rhs = {256'b0, c.opb} % Q_WIDE;
        case (c.cmd)
            CMD_ABSORB: begin
                acc_shadow = field_t'((({257'b0, acc_shadow} << 8) + c.data_byte) % Q_WIDE);
                r = acc_shadow;
            end
            CMD_FINISH: begin
                r = (acc_shadow == '0) ? field_t'(1) : acc_shadow;
                acc_shadow = '0;
            end
            CMD_ADD:    r = field_t'((lhs + rhs) % Q_WIDE);
            CMD_MUL:    r = field_t'((lhs * rhs) % Q_WIDE);
            CMD_REDUCE: r = field_t'(lhs);
            default:    r = '0;
        endcase
        return r;
    endfunction

    // Command driver: present the next queued transaction once the last one is taken.
    always @(negedge aclk) begin : drive_cmds
        field_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct[cmd_q[0].phase]) begin
                nxt = cmd_q.pop_front();
                cur_cmd     <= nxt;
                cur_phase   <= nxt.phase;
                s_cmd       <= nxt.cmd;
                s_data_byte <= nxt.data_byte;
                s_opa_w0    <= nxt.opa[63:0];
                s_opa_w1    <= nxt.opa[127:64];
                s_opa_w2    <= nxt.opa[191:128];
                s_opa_w3    <= nxt.opa[255:192];
                s_opb_w0    <= nxt.opb[63:0];
                s_opb_w1    <= nxt.opb[127:64];
                s_opb_w2    <= nxt.opb[191:128];
                s_opb_w3    <= nxt.opb[255:192];
                s_valid     <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct[cur_phase]);
    end

    // Monitor: check results before logging a new command, so a stray result
    // cannot match an expectation raised at the same edge.
    always @(posedge aclk) begin : check_results
        field_result_t exp_res;
        word_t         got;
        word_t         want;
        if (!aresetn) begin
            s_taken    <= 1'b0;
            acc_shadow = '0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                got = {1'b0, m_res_w3, m_res_w2, m_res_w1, m_res_w0};
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no command outstanding", got));
                end else begin
                    exp_res = result_q.pop_front();
                    want    = {1'b0, exp_res.value};
                    for (int i = 0; i < 4; i++) begin
                        if (got[64*i +: 64] !== want[64*i +: 64])
                            report_mismatch($sformatf(
                                "transaction %0d cmd %0d res_w%0d: got %h, expected %h",
                                exp_res.seq, exp_res.cmd, i, got[64*i +: 64], want[64*i +: 64]));
                    end
                end
            end
            if (s_valid && s_ready) begin
                exp_res.cmd   = cur_cmd.cmd;
                exp_res.seq   = n_accepted;
                exp_res.value = field_step(cur_cmd);
                result_q.push_back(exp_res);
                n_accepted++;
            end
        end
    end

    initial begin : stimulus
        int unsigned sel;
        int unsigned len;
        int unsigned style;
        logic [7:0]  b_val;

        // Directed: zero accumulator on finish, byte extremes, undefined commands
        // leaving acc alone, operands at and around multiples of q.
        push_cmd(CMD_FINISH, 8'hFF, ALL_ONES, ALL_ONES);
        push_cmd(CMD_ABSORB, 8'h00, ALL_ONES, '0);
        push_cmd(CMD_ABSORB, 8'hFF, '0, ALL_ONES);
        push_cmd(CMD_ABSORB, 8'h80, ALL_ONES, ALL_ONES);
        push_cmd(CMD_FINISH, 8'h00, '0, '0);
        push_cmd(CMD_ADD, 8'hFF, '0, '0);
        push_cmd(CMD_ADD, 8'h00, ALL_ONES, ALL_ONES);
        push_cmd(CMD_ADD, 8'h5A, Q_WORD - 1, word_t'(1));
        push_cmd(CMD_ADD, 8'hA5, Q_WORD, Q_WORD - 1);
        push_cmd(CMD_MUL, 8'hFF, '0, ALL_ONES);
        push_cmd(CMD_MUL, 8'h00, ALL_ONES, ALL_ONES);
        push_cmd(CMD_MUL, 8'h00, Q_WORD - 1, Q_WORD - 1);
        push_cmd(CMD_MUL, 8'hFF, Q_WORD * 3 + 3, word_t'(1));
        push_cmd(CMD_REDUCE, 8'h00, '0, ALL_ONES);
        push_cmd(CMD_REDUCE, 8'hFF, Q_WORD - 1, '0);
        push_cmd(CMD_REDUCE, 8'h00, Q_WORD, ALL_ONES);
        push_cmd(CMD_REDUCE, 8'hFF, ALL_ONES, '0);
        push_cmd(CMD_ABSORB, 8'h01, '0, '0);
        push_cmd(CMD_UNDEF_FIRST, 8'hFF, ALL_ONES, ALL_ONES);
        push_cmd(CMD_UNDEF_FIRST + cmd_t'(1), 8'h00, ALL_ONES, '0);
        push_cmd(CMD_UNDEF_LAST, 8'hFF, '0, ALL_ONES);
        push_cmd(CMD_FINISH, 8'hFF, ALL_ONES, ALL_ONES);

        while (n_queued < TOTAL_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 10) begin
                // Byte stream: long runs can wrap past q, some are left open.
                len   = ($urandom_range(3) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
                style = $urandom_range(3);
                repeat (len) begin
                    b_val = (style == 0) ? 8'hFF : (style == 1) ? 8'h00 : 8'($urandom);
                    push_cmd(CMD_ABSORB, b_val, rand_operand(), rand_operand());
                    if ($urandom_range(9) == 0)
                        push_cmd(cmd_t'($urandom_range(CMD_ADD, CMD_REDUCE)), 8'($urandom),
                                 rand_operand(), rand_operand());
                end
                if ($urandom_range(9) != 0)
                    push_cmd(CMD_FINISH, 8'($urandom), rand_operand(), rand_operand());
            end else if (sel < 45) begin
                push_cmd(CMD_MUL, 8'($urandom), rand_operand(), rand_operand());
            end else if (sel < 65) begin
                push_cmd(CMD_ADD, 8'($urandom), rand_operand(), rand_operand());
            end else if (sel < 88) begin
                push_cmd(CMD_REDUCE, 8'($urandom), rand_operand(), rand_operand());
            end else if (sel < 95) begin
                push_cmd(cmd_t'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)), 8'($urandom),
                         rand_operand(), rand_operand());
            end else begin
                push_cmd(CMD_FINISH, 8'($urandom), rand_operand(), rand_operand());
            end
        end

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_valid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        // Hold off so that any surplus result still shows up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
